// File: rtl/omw_pkg.sv
// Package for the omni wheel heading mixer: sizes, wheel constants, back-end states
// and the cosine table generator that is evaluated at elaboration time.
// No dependencies.
package omw_pkg;

  localparam int unsigned SPEED_BITS    = 8;
  localparam int unsigned COS_FRAC_BITS = 14;
  localparam int unsigned ANGLE_BITS    = 9;
  localparam int unsigned WHEELS        = 4;
  localparam int unsigned COS_ENTRIES   = 91;
  localparam int unsigned IDX_BITS      = $clog2(COS_ENTRIES);
  localparam int unsigned TERMS         = 10;

  localparam logic [ANGLE_BITS-1:0] FULL_TURN    = ANGLE_BITS'(360);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(180);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(90);

  // NW, SW, SE, NE
  localparam logic [ANGLE_BITS-1:0] WHEEL_OFFSET [WHEELS] = '{
    ANGLE_BITS'(315), ANGLE_BITS'(225), ANGLE_BITS'(135), ANGLE_BITS'(45)
  };
  localparam logic [WHEELS-1:0] WHEEL_NEGATE = 4'b0110;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  localparam longint unsigned COS_STEP [TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };
  localparam longint unsigned SIN_STEP [TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  function automatic longint unsigned trig_small(input int unsigned d, input bit want_sin);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (longint'(d) * PI_Q30 + 64'd90) / 180;
    x2   = (x * x) >> 30;
    term = want_sin ? x : Q30_ONE;
    sum  = 0;
    for (int n = 0; n < TERMS; n++) begin
      if ((n & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
      term = (term * x2) >> 30;
      if (want_sin) term = term / SIN_STEP[n];
      else term = term / COS_STEP[n];
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  // Magnitude of cos(a) for a in 0..90, rounded to frac fraction bits.
  function automatic longint unsigned cos_mag(input int unsigned a, input int unsigned frac);
    longint unsigned q;
    if (a <= 45) q = trig_small(a, 1'b0);
    else q = trig_small(90 - a, 1'b1);
    return (q + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

// File: rtl/omw_queue.sv
// Two-entry queue between the front and back ends of the heading mixer.
// Depends on nothing but its width parameter.
module omw_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign push_stall_o = (count_q == 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/omw_front.sv
// Front end: accepts heading and speed, folds each wheel angle, looks up cosine,
// forms raw wheel magnitudes and their maximum. Depends on omw_pkg.
module omw_front #(
  parameter int unsigned SpeedBits  = omw_pkg::SPEED_BITS,
  parameter int unsigned CosFracBits = omw_pkg::COS_FRAC_BITS,
  parameter int unsigned JobWidth   = omw_pkg::WHEELS * (SpeedBits + 1) + 2 * SpeedBits + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [omw_pkg::ANGLE_BITS-1:0]     angle_deg_i,
  input  logic [SpeedBits-1:0]               speed_i,
  output logic                               job_valid_o,
  input  logic                               job_stall_i,
  output logic [JobWidth-1:0]                job_o
);
  import omw_pkg::*;

  localparam int unsigned CosW  = CosFracBits + 1;
  localparam int unsigned ProdW = SpeedBits + CosW;

  logic [CosW-1:0] cos_rom [COS_ENTRIES];

  for (genvar g = 0; g < COS_ENTRIES; g++) begin : g_rom
    localparam logic [CosW-1:0] Entry = CosW'(cos_mag(g, CosFracBits));
    assign cos_rom[g] = Entry;
  end

  logic                  a_valid_q;
  logic [IDX_BITS-1:0]   idx_q [WHEELS];
  logic [IDX_BITS-1:0]   idx_d [WHEELS];
  logic [WHEELS-1:0]     neg_q, neg_d;
  logic [SpeedBits-1:0]  spd_q;
  logic [ANGLE_BITS-1:0] ang;
  logic [ANGLE_BITS:0]   wsum [WHEELS];
  logic [ANGLE_BITS-1:0] wang [WHEELS];
  logic [ANGLE_BITS-1:0] fold [WHEELS];
  logic [ProdW-1:0]      prod [WHEELS];
  logic [SpeedBits-1:0]  mag  [WHEELS];
  logic [SpeedBits-1:0]  maxm;

  assign in_stall_o  = a_valid_q && job_stall_i;
  assign job_valid_o = a_valid_q;
  assign ang = (angle_deg_i >= FULL_TURN) ? angle_deg_i - FULL_TURN : angle_deg_i;

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      wsum[w] = {1'b0, ang} + {1'b0, WHEEL_OFFSET[w]};
      if (wsum[w] >= {1'b0, FULL_TURN}) wang[w] = ANGLE_BITS'(wsum[w] - {1'b0, FULL_TURN});
      else wang[w] = wsum[w][ANGLE_BITS-1:0];
      fold[w] = (wang[w] > HALF_TURN) ? FULL_TURN - wang[w] : wang[w];
      neg_d[w] = fold[w] > QUARTER_TURN;
      if (neg_d[w]) idx_d[w] = IDX_BITS'(HALF_TURN - fold[w]);
      else idx_d[w] = IDX_BITS'(fold[w]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      idx_q <= idx_d;
      neg_q <= neg_d;
      spd_q <= speed_i;
    end
  end

  always_comb begin
    maxm = '0;
    for (int w = 0; w < WHEELS; w++) begin
      prod[w] = ProdW'(spd_q) * ProdW'(cos_rom[idx_q[w]]);
      mag[w]  = prod[w][CosFracBits +: SpeedBits];
      if (mag[w] > maxm) maxm = mag[w];
    end
  end

  assign job_o = {neg_q, (maxm == '0), maxm, mag[3], mag[2], mag[1], mag[0], spd_q};

endmodule

// File: rtl/omw_back.sv
// Back end: rescales the four wheel magnitudes by speed/max with a bit-serial
// divider per wheel and splits them into PWM pairs. Depends on omw_pkg.
module omw_back #(
  parameter int unsigned SpeedBits = omw_pkg::SPEED_BITS,
  parameter int unsigned JobWidth  = omw_pkg::WHEELS * (SpeedBits + 1) + 2 * SpeedBits + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_pop_o,
  input  logic [JobWidth-1:0]  job_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SpeedBits-1:0] fwd_o [omw_pkg::WHEELS],
  output logic [SpeedBits-1:0] rev_o [omw_pkg::WHEELS]
);
  import omw_pkg::*;

  localparam int unsigned CntW = $clog2(SpeedBits + 1);
  localparam int unsigned NumW = 2 * SpeedBits;

  bk_state_e state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [SpeedBits-1:0] spd_q, maxm_q;
  logic [SpeedBits-1:0] mag_q [WHEELS];
  logic [SpeedBits-1:0] rem_q [WHEELS];
  logic [SpeedBits-1:0] lo_q  [WHEELS];
  logic [SpeedBits-1:0] rem_d [WHEELS];
  logic [SpeedBits-1:0] lo_d  [WHEELS];
  logic [NumW-1:0]      num   [WHEELS];
  logic [SpeedBits:0]   trial [WHEELS];
  logic [WHEELS-1:0]    neg_q;
  logic                 zero_q;
  logic                 out_valid_q;
  logic [SpeedBits-1:0] fwd_q [WHEELS];
  logic [SpeedBits-1:0] rev_q [WHEELS];
  logic                 out_free, load, emit;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign fwd_o       = fwd_q;
  assign rev_o       = rev_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    load      = 1'b0;
    emit      = 1'b0;
    job_pop_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          load      = 1'b1;
          state_d   = BK_MUL;
        end
      end
      BK_MUL: begin
        cnt_d   = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(SpeedBits - 1)) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      num[w]   = NumW'(mag_q[w]) * NumW'(spd_q);
      trial[w] = {rem_q[w], lo_q[w][SpeedBits-1]};
      rem_d[w] = rem_q[w];
      lo_d[w]  = lo_q[w];
      if (state_q == BK_MUL) begin
        rem_d[w] = num[w][NumW-1:SpeedBits];
        lo_d[w]  = num[w][SpeedBits-1:0];
      end else if (state_q == BK_DIV) begin
        if (trial[w] >= {1'b0, maxm_q}) begin
          rem_d[w] = SpeedBits'(trial[w] - {1'b0, maxm_q});
          lo_d[w]  = {lo_q[w][SpeedBits-2:0], 1'b1};
        end else begin
          rem_d[w] = trial[w][SpeedBits-1:0];
          lo_d[w]  = {lo_q[w][SpeedBits-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      spd_q  <= job_i[SpeedBits-1:0];
      for (int w = 0; w < WHEELS; w++) mag_q[w] <= job_i[SpeedBits*(w+1) +: SpeedBits];
      maxm_q <= job_i[SpeedBits*(WHEELS+1) +: SpeedBits];
      zero_q <= job_i[SpeedBits*(WHEELS+2)];
      neg_q  <= job_i[SpeedBits*(WHEELS+2)+1 +: WHEELS];
    end
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (emit) begin
      for (int w = 0; w < WHEELS; w++) begin
        if (zero_q || lo_q[w] == '0) begin
          fwd_q[w] <= '0;
          rev_q[w] <= '0;
        end else if (neg_q[w] ^ WHEEL_NEGATE[w]) begin
          fwd_q[w] <= '0;
          rev_q[w] <= lo_q[w];
        end else begin
          fwd_q[w] <= lo_q[w];
          rev_q[w] <= '0;
        end
      end
    end
  end

endmodule

// File: rtl/omni_wheel_heading_mixer_top.sv
// Omni wheel heading mixer: turns a heading and a speed into forward/reverse PWM
// duties for four omni wheels (NW, SW, SE, NE).
// Input channel: in_valid_i / in_stall_o with angle_deg_i (degrees, reduced
// modulo 360) and speed_i. Output channel: out_valid_o / out_stall_i with eight
// duty fields, one result per input, in input order.
// The front end takes an item every cycle unless the queue is full: one register
// stage folds the wheel angles, then cosine lookup, multiply and the maximum feed
// a two-entry queue. The back end pulls one item, forms magnitude*speed, then
// divides by the maximum one quotient bit per cycle, all four wheels in parallel.
// From acceptance, an item passes the front-end register and the queue, then the
// back-end idle, multiply, divide and done states. The back end finishes one
// item before it takes the next, so its divider limits sustained throughput.
// A finished result waits in the output register while the back end takes the
// next item; when the receiver stalls, the queue fills and in_stall_o rises.
// An all-zero maximum (for example speed zero) gives all duties zero.
// Reset empties the pipeline and queue; there is no other state.
module omni_wheel_heading_mixer_top #(
  parameter int unsigned SpeedBits   = omw_pkg::SPEED_BITS,
  parameter int unsigned CosFracBits = omw_pkg::COS_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [omw_pkg::ANGLE_BITS-1:0] angle_deg_i,
  input  logic [SpeedBits-1:0]           speed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [SpeedBits-1:0]           nw_fwd_pwm_o,
  output logic [SpeedBits-1:0]           nw_rev_pwm_o,
  output logic [SpeedBits-1:0]           sw_fwd_pwm_o,
  output logic [SpeedBits-1:0]           sw_rev_pwm_o,
  output logic [SpeedBits-1:0]           se_fwd_pwm_o,
  output logic [SpeedBits-1:0]           se_rev_pwm_o,
  output logic [SpeedBits-1:0]           ne_fwd_pwm_o,
  output logic [SpeedBits-1:0]           ne_rev_pwm_o
);
  import omw_pkg::*;

  localparam int unsigned JobW = WHEELS * (SpeedBits + 1) + 2 * SpeedBits + 1;

  logic            f_valid, f_stall, q_valid, q_pop;
  logic [JobW-1:0] f_job, q_job;
  logic [SpeedBits-1:0] fwd [WHEELS];
  logic [SpeedBits-1:0] rev [WHEELS];

  omw_front #(
    .SpeedBits  (SpeedBits),
    .CosFracBits(CosFracBits),
    .JobWidth   (JobW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .angle_deg_i(angle_deg_i),
    .speed_i    (speed_i),
    .job_valid_o(f_valid),
    .job_stall_i(f_stall),
    .job_o      (f_job)
  );

  omw_queue #(
    .Width(JobW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_stall_o(f_stall),
    .push_data_i (f_job),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_job)
  );

  omw_back #(
    .SpeedBits(SpeedBits),
    .JobWidth (JobW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_pop_o  (q_pop),
    .job_i      (q_job),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .fwd_o      (fwd),
    .rev_o      (rev)
  );

  assign nw_fwd_pwm_o = fwd[0];
  assign nw_rev_pwm_o = rev[0];
  assign sw_fwd_pwm_o = fwd[1];
  assign sw_rev_pwm_o = rev[1];
  assign se_fwd_pwm_o = fwd[2];
  assign se_rev_pwm_o = rev[2];
  assign ne_fwd_pwm_o = fwd[3];
  assign ne_rev_pwm_o = rev[3];

`ifndef SYNTH
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && f_stall) |=> f_valid) else $error("front item dropped while queue full");

  a_pair_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((nw_fwd_pwm_o != '0 && nw_rev_pwm_o != '0) ||
                      (sw_fwd_pwm_o != '0 && sw_rev_pwm_o != '0) ||
                      (se_fwd_pwm_o != '0 && se_rev_pwm_o != '0) ||
                      (ne_fwd_pwm_o != '0 && ne_rev_pwm_o != '0)))
    else $error("wheel drives forward and reverse at once");
`endif

endmodule
